FILE: hdl/i2c_eeprom_access_sequencer_unit_assert.svh
// ---------------------------------------------------------------------------
// I2C EEPROM sequencer assertion macros
// Concurrent assertion shorthands shared by the sequencer checkers.
// ---------------------------------------------------------------------------
`ifndef I2C_EEPROM_ACCESS_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_EEPROM_ACCESS_SEQUENCER_UNIT_ASSERT_SVH

// check a property at every rising clock edge outside reset
`define EAS_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a payload holds while its transfer is stalled
`define EAS_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && (stl)) |=> $stable(sig)) else $error(msg);

`endif

FILE: hdl/i2ceas_pkg.sv
// ---------------------------------------------------------------------------
// I2C EEPROM sequencer package
// Types, codes, reset values and helpers shared by the sequencer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package i2ceas_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    // command codes
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_DATA  = 3'd2;
    localparam logic [2:0] CMD_ACK   = 3'd3;
    localparam logic [2:0] CMD_RRESP = 3'd4;

    // bus operation codes
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_SEND    = 3'd3;
    localparam logic [2:0] OP_RD_ACK  = 3'd4;
    localparam logic [2:0] OP_RD_NACK = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
    localparam logic [1:0] CFG_ADDR_BYTES = 2'd1;
    localparam logic [1:0] CFG_PAGE_LOG2  = 2'd2;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd3;

    localparam logic [7:0]  DEV_ADDR_RST   = 8'd160;
    localparam logic [1:0]  ADDR_BYTES_RST = 2'd1;
    localparam logic [3:0]  PAGE_LOG2_RST  = 4'd3;
    localparam logic [15:0] POLL_LIMIT_RST = 16'd1000;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RD_DEV,
        PH_AHI,
        PH_ALO,
        PH_RD_DEVR,
        PH_RD_DATA,
        PH_WR_POLL,
        PH_WR_NEED,
        PH_WR_DACK
    } t_phase;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] mem_address;
        logic [15:0] byte_count;
        logic [7:0]  data_byte;
        logic        nack;
    } t_in_item;

    typedef struct packed {
        logic [2:0] bus_op;
        logic [7:0] bus_byte;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       want_data;
        logic       done_res;
        logic       success;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [1:0]  address_byte_count;
        logic [3:0]  page_size_log2;
        logic [15:0] poll_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           cnt;
        t_out_item [2:0]      ent;
    } t_batch;

    function automatic t_out_item f_res(
        input logic [2:0] op,
        input logic [7:0] bbyte,
        input logic [7:0] rbyte,
        input logic       rvalid,
        input logic       want,
        input logic       done,
        input logic       succ
    );
        t_out_item r;
        r.bus_op     = op;
        r.bus_byte   = bbyte;
        r.read_byte  = rbyte;
        r.read_valid = rvalid;
        r.want_data  = want;
        r.done_res   = done;
        r.success    = succ;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/i2ceas_core.sv
// ---------------------------------------------------------------------------
// I2C EEPROM sequencer core
// Request state and the single-pass step that turns one item into results.
// ---------------------------------------------------------------------------
`default_nettype none

module i2ceas_core import i2ceas_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_batch        o_batch
);

    t_phase                 r_phase, n_phase;
    logic                   r_is_read, n_is_read;
    logic [15:0]            r_addr, n_addr;
    logic [COUNT_WIDTH-1:0] r_done, n_done;
    logic [COUNT_WIDTH-1:0] r_total, n_total;
    logic [15:0]            r_poll, n_poll;

    logic [COUNT_WIDTH-1:0] w_cnt;
    logic [COUNT_WIDTH-1:0] w_done_p1;
    logic [COUNT_WIDTH-1:0] w_done_p2;
    logic [15:0]            w_addr_p1;
    logic [15:0]            w_page_mask;
    logic [7:0]             w_dev_wr;
    logic [7:0]             w_dev_rd;
    t_out_item              w_fail;

    assign w_cnt       = COUNT_WIDTH'(i_item.byte_count);
    assign w_done_p1   = r_done + COUNT_WIDTH'(1);
    assign w_done_p2   = r_done + COUNT_WIDTH'(2);
    assign w_addr_p1   = r_addr + 16'd1;
    assign w_page_mask = ~(16'hFFFF << i_cfg.page_size_log2);
    assign w_dev_wr    = i_cfg.device_address & 8'hFE;
    assign w_dev_rd    = i_cfg.device_address | 8'h01;
    assign w_fail      = f_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_read <= 1'b0;
            r_addr    <= '0;
            r_done    <= '0;
            r_total   <= '0;
            r_poll    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_is_read <= n_is_read;
            r_addr    <= n_addr;
            r_done    <= n_done;
            r_total   <= n_total;
            r_poll    <= n_poll;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_addr    = r_addr;
        n_done    = r_done;
        n_total   = r_total;
        n_poll    = r_poll;
        o_batch.cnt = 2'd0;
        o_batch.ent = '0;
        if (i_fire) begin
            unique case (i_item.command)
                CMD_READ: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_read = 1'b1;
                        n_addr    = i_item.mem_address;
                        n_total   = w_cnt;
                        n_done    = '0;
                        o_batch.ent[0] = f_res(OP_START, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                        o_batch.ent[1] = f_res(OP_SEND, w_dev_wr, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                        o_batch.cnt = 2'd2;
                        n_phase = PH_RD_DEV;
                    end
                end
                CMD_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_read = 1'b0;
                        n_addr    = i_item.mem_address;
                        n_total   = w_cnt;
                        n_done    = '0;
                        if (w_cnt == '0) begin
                            o_batch.ent[0] = f_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
                            o_batch.cnt = 2'd1;
                            n_phase = PH_IDLE;
                        end else begin
                            o_batch.ent[0] = f_res(OP_STOP, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                            o_batch.ent[1] = f_res(OP_START, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                            o_batch.ent[2] = f_res(OP_SEND, w_dev_wr, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                            o_batch.cnt = 2'd3;
                            n_poll  = 16'd1;
                            n_phase = PH_WR_POLL;
                        end
                    end
                end
                CMD_DATA: begin
                    if (r_phase == PH_WR_NEED) begin
                        o_batch.ent[0] = f_res(OP_SEND, i_item.data_byte, 8'd0,
                                               1'b0, 1'b0, 1'b0, 1'b0);
                        o_batch.cnt = 2'd1;
                        n_phase = PH_WR_DACK;
                    end
                end
                CMD_ACK: begin
                    unique case (r_phase)
                        PH_RD_DEV, PH_WR_POLL: begin
                            if (i_item.nack && r_phase == PH_RD_DEV) begin
                                o_batch.ent[0] = w_fail;
                                o_batch.cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end else if (i_item.nack && r_poll >= i_cfg.poll_limit) begin
                                o_batch.ent[0] = w_fail;
                                o_batch.cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end else if (i_item.nack) begin
                                n_poll = r_poll + 16'd1;
                                o_batch.ent[0] = f_res(OP_START, 8'd0, 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0);
                                o_batch.ent[1] = f_res(OP_SEND, w_dev_wr, 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0);
                                o_batch.cnt = 2'd2;
                            end else if (i_cfg.address_byte_count == 2'd1) begin
                                o_batch.ent[0] = f_res(OP_SEND, r_addr[7:0], 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0);
                                o_batch.cnt = 2'd1;
                                n_phase = PH_ALO;
                            end else begin
                                o_batch.ent[0] = f_res(OP_SEND, r_addr[15:8], 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0);
                                o_batch.cnt = 2'd1;
                                n_phase = PH_AHI;
                            end
                        end
                        PH_AHI: begin
                            if (i_item.nack) begin
                                o_batch.ent[0] = w_fail;
                                o_batch.cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end else begin
                                o_batch.ent[0] = f_res(OP_SEND, r_addr[7:0], 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0);
                                o_batch.cnt = 2'd1;
                                n_phase = PH_ALO;
                            end
                        end
                        PH_ALO: begin
                            if (i_item.nack) begin
                                o_batch.ent[0] = w_fail;
                                o_batch.cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end else if (r_is_read) begin
                                o_batch.ent[0] = f_res(OP_START, 8'd0, 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0);
                                o_batch.ent[1] = f_res(OP_SEND, w_dev_rd, 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0);
                                o_batch.cnt = 2'd2;
                                n_phase = PH_RD_DEVR;
                            end else begin
                                o_batch.ent[0] = f_res(OP_NONE, 8'd0, 8'd0,
                                                       1'b0, 1'b1, 1'b0, 1'b0);
                                o_batch.cnt = 2'd1;
                                n_phase = PH_WR_NEED;
                            end
                        end
                        PH_RD_DEVR: begin
                            o_batch.cnt = 2'd1;
                            if (i_item.nack) begin
                                o_batch.ent[0] = w_fail;
                                n_phase = PH_IDLE;
                            end else if (r_total == '0) begin
                                o_batch.ent[0] = f_res(OP_STOP, 8'd0, 8'd0,
                                                       1'b0, 1'b0, 1'b1, 1'b1);
                                n_phase = PH_IDLE;
                            end else begin
                                o_batch.ent[0] = f_res(
                                    (w_done_p1 == r_total) ? OP_RD_NACK : OP_RD_ACK,
                                    8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                                n_phase = PH_RD_DATA;
                            end
                        end
                        PH_WR_DACK: begin
                            if (i_item.nack) begin
                                o_batch.ent[0] = w_fail;
                                o_batch.cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_addr = w_addr_p1;
                                n_done = w_done_p1;
                                if (w_done_p1 == r_total) begin
                                    o_batch.ent[0] = f_res(OP_STOP, 8'd0, 8'd0,
                                                           1'b0, 1'b0, 1'b1, 1'b1);
                                    o_batch.cnt = 2'd1;
                                    n_phase = PH_IDLE;
                                end else if ((w_addr_p1 & w_page_mask) == 16'd0) begin
                                    o_batch.ent[0] = f_res(OP_STOP, 8'd0, 8'd0,
                                                           1'b0, 1'b0, 1'b0, 1'b0);
                                    o_batch.ent[1] = f_res(OP_START, 8'd0, 8'd0,
                                                           1'b0, 1'b0, 1'b0, 1'b0);
                                    o_batch.ent[2] = f_res(OP_SEND, w_dev_wr, 8'd0,
                                                           1'b0, 1'b0, 1'b0, 1'b0);
                                    o_batch.cnt = 2'd3;
                                    n_poll  = 16'd1;
                                    n_phase = PH_WR_POLL;
                                end else begin
                                    o_batch.ent[0] = f_res(OP_NONE, 8'd0, 8'd0,
                                                           1'b0, 1'b1, 1'b0, 1'b0);
                                    o_batch.cnt = 2'd1;
                                    n_phase = PH_WR_NEED;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_RRESP: begin
                    if (r_phase == PH_RD_DATA) begin
                        n_done = w_done_p1;
                        o_batch.cnt = 2'd1;
                        if (w_done_p1 == r_total) begin
                            o_batch.ent[0] = f_res(OP_STOP, 8'd0, i_item.data_byte,
                                                   1'b1, 1'b0, 1'b1, 1'b1);
                            n_phase = PH_IDLE;
                        end else begin
                            o_batch.ent[0] = f_res(
                                (w_done_p2 == r_total) ? OP_RD_NACK : OP_RD_ACK,
                                8'd0, i_item.data_byte, 1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2ceas_outq.sv
// ---------------------------------------------------------------------------
// I2C EEPROM sequencer result queue
// Holds the results of one item and hands them out one transfer at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module i2ceas_outq import i2ceas_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_batch i_batch,
    input  wire logic   i_stall,
    output logic        o_valid,
    output t_out_item   o_data,
    output logic        o_room
);

    t_out_item [2:0] r_q;
    logic [1:0]      r_cnt;
    logic            w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && !i_stall;
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && !i_stall);

    always_comb begin
        o_data      = r_q[0];
        o_data.last = (r_cnt == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_batch.ent;
        end else if (w_pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2c_eeprom_access_sequencer_unit.sv
// An accepted item waits in the input register until the result queue has room,
// is then stepped by the core, and its results are loaded into the result queue.
// Results leave at one per cycle while the output is not stalled; an item yields
// at most three, and the next item can be stepped as the last of them leaves.
// Reset (synchronous, active low) returns to idle, drops queued results and
// restores the configuration defaults.
// ---------------------------------------------------------------------------
// I2C EEPROM access sequencer
// Input register, configuration registers, sequencing core and result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_access_sequencer_unit import i2ceas_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_in_item r_in;
    logic     r_in_valid;
    t_cfg     r_cfg;
    t_batch   w_batch;
    logic     w_room;
    logic     w_fire;
    logic     w_take;

    assign o_cfg_ready = 1'b1;
    assign w_fire      = r_in_valid && w_room;
    assign o_in_stall  = r_in_valid && !w_room;
    assign w_take      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address     <= DEV_ADDR_RST;
            r_cfg.address_byte_count <= ADDR_BYTES_RST;
            r_cfg.page_size_log2     <= PAGE_LOG2_RST;
            r_cfg.poll_limit         <= POLL_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEV_ADDR:   r_cfg.device_address     <= i_cfg_data[7:0];
                CFG_ADDR_BYTES: r_cfg.address_byte_count <= i_cfg_data[1:0];
                CFG_PAGE_LOG2:  r_cfg.page_size_log2     <= i_cfg_data[3:0];
                CFG_POLL_LIMIT: r_cfg.poll_limit         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    i2ceas_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_batch (w_batch)
    );

    i2ceas_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_batch (w_batch),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_room  (w_room)
    );

endmodule

`default_nettype wire

FILE: hdl/i2ceas_checker.sv
// ---------------------------------------------------------------------------
// I2C EEPROM sequencer port checker
// Watches the sequencer ports for inconsistent results and unstable payloads.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_eeprom_access_sequencer_unit_assert.svh"

module i2ceas_checker import i2ceas_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    logic w_done;
    logic w_final_stop;
    logic w_read;
    logic w_read_op;
    logic w_want;
    logic w_quiet_last;

    assign w_done       = o_out_valid && o_out_data.done_res;
    assign w_final_stop = (o_out_data.bus_op == OP_STOP) && o_out_data.last;
    assign w_read       = o_out_valid && o_out_data.read_valid;
    assign w_read_op    = (o_out_data.bus_op == OP_RD_ACK) ||
                          (o_out_data.bus_op == OP_RD_NACK) ||
                          (o_out_data.bus_op == OP_STOP);
    assign w_want       = o_out_valid && o_out_data.want_data;
    assign w_quiet_last = (o_out_data.bus_op == OP_NONE) && o_out_data.last &&
                          !o_out_data.done_res;

    `EAS_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_stall, o_out_data, "result moved")
    `EAS_ASSERT_PROP(a_done_stop, i_clk, i_rst_n, w_done |-> w_final_stop, "done without stop")
    `EAS_ASSERT_PROP(a_read_op, i_clk, i_rst_n, w_read |-> w_read_op, "read byte on wrong op")
    `EAS_ASSERT_PROP(a_want_idle, i_clk, i_rst_n, w_want |-> w_quiet_last, "data request not idle")

endmodule

bind i2c_eeprom_access_sequencer_unit i2ceas_checker u_chk (.*);

`default_nettype wire
